// File: sv/char_lcd_nibble_write_sequencer_defines.svh
// Assertion helpers used by the clcd_back module.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clcd assertion failed");

// Next-cycle implication, disabled during reset.
`define CLCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clcd assertion failed");

`endif

// File: sv/clcd_pkg.sv
package clcd_pkg;

    // Request kinds carried in the action field.
    localparam logic [2:0] ACT_INIT    = 3'd0;
    localparam logic [2:0] ACT_COMMAND = 3'd1;
    localparam logic [2:0] ACT_TEXT    = 3'd2;
    localparam logic [2:0] ACT_CLEAR   = 3'd3;
    localparam logic [2:0] ACT_SETPOS  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] REG_COMMAND_WAIT = 2'd1;
    localparam logic [1:0] REG_CLEAR_WAIT   = 2'd2;

    // Register reset values.
    localparam logic [7:0]  ENABLE_PULSE_RESET = 8'd1;
    localparam logic [15:0] COMMAND_WAIT_RESET = 16'd50;
    localparam logic [15:0] CLEAR_WAIT_RESET   = 16'd2000;

    // Display commands.
    localparam logic [7:0] CMD_CLEAR = 8'h01;

    // Power-up waits in microseconds.
    localparam logic [15:0] WAIT_POWER_UP = 16'd20000;
    localparam logic [15:0] WAIT_LONG     = 16'd5000;
    localparam logic [15:0] WAIT_SHORT    = 16'd150;

    // Last nibble index of an init run and of a single byte.
    localparam logic [3:0] INIT_LAST_NIB = 4'd11;
    localparam logic [3:0] BYTE_LAST_NIB = 4'd1;

    // Strobe phases of one nibble.
    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic       trail_clear;
        logic [7:0] code_val;
    } clcd_req_t;

    // Timing registers as seen by the back end.
    typedef struct packed {
        logic [7:0]  enable_pulse_us;
        logic [15:0] command_wait_us;
        logic [15:0] clear_wait_us;
    } clcd_cfg_t;

    // DDRAM base address of each display line.
    function automatic logic [7:0] line_base(input logic [1:0] line_idx);
        logic [7:0] base;
        case (line_idx)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base;
    endfunction

    // Nibble sent at each step of the init run: 3, 3, 3, 2, then the
    // bytes 0x28, 0x08, 0x0C and 0x06 high nibble first.
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5, 4'd7:       nib = 4'h8;
            4'd9:             nib = 4'hC;
            4'd11:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

// File: sv/clcd_front.sv
module clcd_front (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [2:0]          s_axis_tuser,
    input  logic [23:0]         s_axis_tdata,
    output logic                push,
    output clcd_pkg::clcd_req_t push_req,
    input  logic                q_ready
);

    logic [7:0] code_in;
    logic [2:0] line_in;
    logic [5:0] column_in;
    logic       keep;

    assign code_in   = s_axis_tdata[7:0];
    assign line_in   = s_axis_tdata[10:8];
    assign column_in = s_axis_tdata[16:11];

    // Items are taken whenever the queue has room; ones that give no writes are dropped.
    assign s_axis_tready = q_ready;
    assign push = s_axis_tvalid && q_ready && keep;

    // Classify the request and work out the byte it sends.
    always_comb begin
        keep                 = 1'b1;
        push_req.is_init     = 1'b0;
        push_req.rs          = 1'b0;
        push_req.trail_clear = 1'b0;
        push_req.code_val    = code_in;
        case (s_axis_tuser)
            clcd_pkg::ACT_INIT: begin
                push_req.is_init = 1'b1;
            end
            clcd_pkg::ACT_COMMAND: begin
                push_req.rs = 1'b0;
            end
            clcd_pkg::ACT_TEXT: begin
                push_req.rs = 1'b1;
            end
            clcd_pkg::ACT_CLEAR: begin
                push_req.trail_clear = 1'b1;
                push_req.code_val    = clcd_pkg::CMD_CLEAR;
            end
            clcd_pkg::ACT_SETPOS: begin
                keep = !line_in[2];
                push_req.code_val = clcd_pkg::line_base(line_in[1:0]) + {2'b00, column_in};
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/clcd_queue.sv
module clcd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  clcd_pkg::clcd_req_t push_req,
    output logic                q_ready,
    input  logic                pop,
    output logic                q_valid,
    output clcd_pkg::clcd_req_t q_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    clcd_pkg::clcd_req_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_ready = count_reg != FULL_CNT;
    assign q_valid = count_reg != '0;
    assign q_data  = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// File: sv/clcd_back.sv
`include "char_lcd_nibble_write_sequencer_defines.svh"

module clcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  clcd_pkg::clcd_cfg_t cfg,
    input  logic                q_valid,
    input  clcd_pkg::clcd_req_t q_data,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,
    output logic                m_axis_tlast
);

    clcd_pkg::clcd_req_t req_reg, req_next;
    logic        busy_reg, busy_next;
    logic [3:0]  nib_reg, nib_next;
    logic [1:0]  ph_reg, ph_next;
    logic [15:0] pending_reg, pending_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_pins_reg, m_pins_next;
    logic [15:0] m_wait_reg, m_wait_next;
    logic        m_last_reg, m_last_next;

    logic        advance;
    logic        is_last;
    logic [3:0]  last_nib;
    logic [3:0]  nibble;
    logic [15:0] lead;
    logic [16:0] power_sum;
    logic [15:0] power_wait;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_wait_reg, m_pins_reg};
    assign m_axis_tlast  = m_last_reg;

    // Step control: one pin write per cycle while the output register can take it.
    assign advance  = busy_reg && (!m_valid_reg || m_axis_tready);
    assign last_nib = req_reg.is_init ? clcd_pkg::INIT_LAST_NIB : clcd_pkg::BYTE_LAST_NIB;
    assign is_last  = (ph_reg == clcd_pkg::PH_LOW) && (nib_reg == last_nib);
    assign pop      = q_valid && (!busy_reg || (advance && is_last));

    // Power-up wait plus the held trailing wait, saturating.
    assign power_sum  = {1'b0, pending_reg} + {1'b0, clcd_pkg::WAIT_POWER_UP};
    assign power_wait = power_sum[16] ? 16'hFFFF : power_sum[15:0];

    // Nibble value and the wait before its setup write.
    always_comb begin
        if (req_reg.is_init) begin
            nibble = clcd_pkg::init_nibble(nib_reg);
            case (nib_reg)
                4'd0:              lead = power_wait;
                4'd1, 4'd3, 4'd4:  lead = clcd_pkg::WAIT_LONG;
                4'd2:              lead = clcd_pkg::WAIT_SHORT;
                4'd6, 4'd8, 4'd10: lead = cfg.command_wait_us;
                default:           lead = 16'd0;
            endcase
        end else begin
            nibble = nib_reg[0] ? req_reg.code_val[3:0] : req_reg.code_val[7:4];
            lead   = (nib_reg == 4'd0) ? pending_reg : 16'd0;
        end
    end

    // Next state of the sequencer and the output register.
    always_comb begin
        req_next     = req_reg;
        busy_next    = busy_reg;
        nib_next     = nib_reg;
        ph_next      = ph_reg;
        pending_next = pending_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_pins_next  = m_pins_reg;
        m_wait_next  = m_wait_reg;
        m_last_next  = m_last_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_pins_next  = {nibble, 2'b00, req_reg.rs, ph_reg == clcd_pkg::PH_HIGH};
            m_wait_next  = (ph_reg == clcd_pkg::PH_SETUP) ? lead
                                                          : {8'd0, cfg.enable_pulse_us};
            m_last_next  = is_last;
            if (is_last) begin
                busy_next    = 1'b0;
                pending_next = req_reg.trail_clear ? cfg.clear_wait_us : cfg.command_wait_us;
            end else if (ph_reg == clcd_pkg::PH_LOW) begin
                ph_next  = clcd_pkg::PH_SETUP;
                nib_next = nib_reg + 4'd1;
            end else begin
                ph_next = ph_reg + 2'd1;
            end
        end
        if (pop) begin
            req_next  = q_data;
            busy_next = 1'b1;
            nib_next  = 4'd0;
            ph_next   = clcd_pkg::PH_SETUP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            nib_reg     <= 4'd0;
            ph_reg      <= clcd_pkg::PH_SETUP;
            pending_reg <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            nib_reg     <= nib_next;
            ph_reg      <= ph_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_pins_reg <= m_pins_next;
        m_wait_reg <= m_wait_next;
        m_last_reg <= m_last_next;
    end

    // The final write of a request always leaves enable low.
    `CLCD_ASSERT_NOW(a_last_enable_low, aclk, aresetn, m_valid_reg && m_last_reg, !m_pins_reg[0])
    // Enable high is always preceded by the configured pulse wait.
    `CLCD_ASSERT_NOW(a_strobe_wait, aclk, aresetn, m_valid_reg && m_pins_reg[0], m_wait_reg == {8'd0, cfg.enable_pulse_us})
    // A newly taken request starts at its first setup write.
    `CLCD_ASSERT_NEXT(a_pop_start, aclk, aresetn, pop, busy_reg && nib_reg == 4'd0 && ph_reg == clcd_pkg::PH_SETUP)

endmodule

// File: sv/char_lcd_nibble_write_sequencer.sv
// Character LCD write sequencer for a 4-bit HD44780-style bus.
// Input channel s_axis: one request per transaction; tuser carries the action,
// tdata the code byte, display line and column. Requests that produce no
// pin writes (unknown actions, lines 4 to 7) are accepted and dropped.
// Output channel m_axis: one pin write per transaction; tdata holds the pin
// value and the wait in microseconds before driving it, tlast marks the final
// write of a request. The trailing wait of a request becomes the first
// wait of the next one, added to the power-up wait when that is init.
// Throughput: the back end emits one pin write per cycle while m_axis is not
// stalled, so a command, text, clear or set-position request is 6 writes and init 36.
// When the back end is free, an accepted request passes through the queue and the
// request register before its first write. A small queue between the classifier
// and the back end lets requests be accepted while earlier ones are still being sent.
// When m_axis_tready is low the output register holds its write and the back
// end pauses; the input keeps accepting until the queue fills.
// Reset (aresetn low, synchronous) empties the queue, clears the held wait and
// restores the timing registers to 1, 50 and 2000 microseconds.
// Timing registers are written over APB at byte addresses 0, 4 and 8.
module char_lcd_nibble_write_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    input  logic [23:0] s_axis_tdata,   // [7:0] code, [10:8] line, [16:11] column, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] pins, [23:8] wait_before_us
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    clcd_pkg::clcd_cfg_t cfg_reg, cfg_next;
    clcd_pkg::clcd_req_t push_req;
    clcd_pkg::clcd_req_t q_data;
    logic push;
    logic pop;
    logic q_ready;
    logic q_valid;
    logic cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (paddr[3:2])
                clcd_pkg::REG_ENABLE_PULSE: cfg_next.enable_pulse_us = pwdata[7:0];
                clcd_pkg::REG_COMMAND_WAIT: cfg_next.command_wait_us = pwdata[15:0];
                clcd_pkg::REG_CLEAR_WAIT:   cfg_next.clear_wait_us   = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            clcd_pkg::REG_ENABLE_PULSE: prdata = {24'd0, cfg_reg.enable_pulse_us};
            clcd_pkg::REG_COMMAND_WAIT: prdata = {16'd0, cfg_reg.command_wait_us};
            clcd_pkg::REG_CLEAR_WAIT:   prdata = {16'd0, cfg_reg.clear_wait_us};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_pulse_us <= clcd_pkg::ENABLE_PULSE_RESET;
            cfg_reg.command_wait_us <= clcd_pkg::COMMAND_WAIT_RESET;
            cfg_reg.clear_wait_us   <= clcd_pkg::CLEAR_WAIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Request classifier.
    clcd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .push          (push),
        .push_req      (push_req),
        .q_ready       (q_ready)
    );

    // Request queue.
    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    // Pin write sequencer.
    clcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: tb/sv/char_lcd_nibble_write_sequencer_tb.sv
// Init sequence: the power-up nibbles and the bytes sent after them.
localparam logic [7:0] LCD_NIB_8BIT       = 8'h30;
localparam logic [7:0] LCD_NIB_4BIT       = 8'h20;
localparam logic [7:0] LCD_FUNC_SET_2LINE = 8'h28;
localparam logic [7:0] LCD_DISPLAY_OFF    = 8'h08;
localparam logic [7:0] LCD_DISPLAY_ON     = 8'h0C;
localparam logic [7:0] LCD_ENTRY_MODE     = 8'h06;

// Actions without a meaning, the register index past the last register, and the last valid line.
localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;
localparam logic [1:0] REG_SPARE        = 2'd3;
localparam logic [2:0] LINE_LAST_VALID  = 3'd3;

// Tracks the expected pin writes of the sequencer and checks the actual ones.
class lcd_write_scoreboard;
    typedef struct packed {
        logic [7:0]  pins;
        logic [15:0] wait_us;
        logic        last_flag;
    } pin_write_t;

    pin_write_t  expected_writes[$];
    logic [7:0]  enable_pulse_us;
    logic [15:0] command_wait_us;
    logic [15:0] clear_wait_us;
    logic [15:0] held_wait_us;
    int          errors;

    function new();
        enable_pulse_us = clcd_pkg::ENABLE_PULSE_RESET;
        command_wait_us = clcd_pkg::COMMAND_WAIT_RESET;
        clear_wait_us   = clcd_pkg::CLEAR_WAIT_RESET;
        held_wait_us    = '0;
        errors          = 0;
    endfunction

    function int count();
        return expected_writes.size();
    endfunction

    // Register writes at unknown indexes leave the timing unchanged.
    function void write_register(logic [3:0] addr, logic [31:0] value);
        case (addr[3:2])
            clcd_pkg::REG_ENABLE_PULSE: enable_pulse_us = value[7:0];
            clcd_pkg::REG_COMMAND_WAIT: command_wait_us = value[15:0];
            clcd_pkg::REG_CLEAR_WAIT:   clear_wait_us   = value[15:0];
            default:                    ;
        endcase
    endfunction

    function void push_write(logic [7:0] pins, logic [15:0] wait_us);
        pin_write_t w;
        w.pins      = pins;
        w.wait_us   = wait_us;
        w.last_flag = 1'b0;
        expected_writes.push_back(w);
    endfunction

    // One nibble: setup, enable high, enable low.
    function void push_nibble(logic [7:0] nib_src, logic rs, logic [15:0] lead_us);
        logic [7:0] p;
        p = {nib_src[7:4], 2'b00, rs, 1'b0};
        push_write(p, lead_us);
        push_write(p | 8'h01, {8'h00, enable_pulse_us});
        push_write(p, {8'h00, enable_pulse_us});
    endfunction

    function void push_code(logic [7:0] val, logic rs, logic [15:0] lead_us);
        push_nibble(val, rs, lead_us);
        push_nibble({val[3:0], 4'h0}, rs, 16'd0);
    endfunction

    // Expands one accepted request into its pin writes.
    function void note_request(logic [2:0] action, logic [7:0] code_val,
                               logic [2:0] line_no, logic [5:0] column);
        logic [16:0] power_up_sum;
        logic [15:0] trail_us;
        logic [7:0]  addr_val;
        logic        emits;
        pin_write_t  w;
        emits    = 1'b1;
        trail_us = command_wait_us;
        case (action)
            clcd_pkg::ACT_INIT: begin
                // The held wait plus the power-up wait saturates at 16 bits.
                power_up_sum = {1'b0, held_wait_us} + {1'b0, clcd_pkg::WAIT_POWER_UP};
                push_nibble(LCD_NIB_8BIT, 1'b0,
                            power_up_sum[16] ? 16'hFFFF : power_up_sum[15:0]);
                push_nibble(LCD_NIB_8BIT, 1'b0, clcd_pkg::WAIT_LONG);
                push_nibble(LCD_NIB_8BIT, 1'b0, clcd_pkg::WAIT_SHORT);
                push_nibble(LCD_NIB_4BIT, 1'b0, clcd_pkg::WAIT_LONG);
                push_code(LCD_FUNC_SET_2LINE, 1'b0, clcd_pkg::WAIT_LONG);
                push_code(LCD_DISPLAY_OFF, 1'b0, command_wait_us);
                push_code(LCD_DISPLAY_ON, 1'b0, command_wait_us);
                push_code(LCD_ENTRY_MODE, 1'b0, command_wait_us);
            end
            clcd_pkg::ACT_COMMAND, clcd_pkg::ACT_TEXT: begin
                push_code(code_val, action == clcd_pkg::ACT_TEXT, held_wait_us);
            end
            clcd_pkg::ACT_CLEAR: begin
                push_code(clcd_pkg::CMD_CLEAR, 1'b0, held_wait_us);
                trail_us = clear_wait_us;
            end
            clcd_pkg::ACT_SETPOS: begin
                case (line_no)
                    3'd0:    addr_val = 8'h80;
                    3'd1:    addr_val = 8'hC0;
                    3'd2:    addr_val = 8'h94;
                    3'd3:    addr_val = 8'hD4;
                    default: emits = 1'b0;
                endcase
                if (emits) begin
                    push_code(addr_val + {2'b00, column}, 1'b0, held_wait_us);
                end
            end
            default: emits = 1'b0;
        endcase
        // Dropped requests keep the held wait as it was.
        if (emits) begin
            w = expected_writes.pop_back();
            w.last_flag = 1'b1;
            expected_writes.push_back(w);
            held_wait_us = trail_us;
        end
    endfunction

    function void report(string field, logic [23:0] exp_val, logic [23:0] act_val);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, field, exp_val, act_val);
    endfunction

    function void check_write(logic [7:0] pins, logic [15:0] wait_us, logic last_flag);
        pin_write_t w;
        if (expected_writes.size() == 0) begin
            report("unexpected pin write", 24'h0, {wait_us, pins});
            return;
        end
        w = expected_writes.pop_front();
        if (pins !== w.pins) report("pins", w.pins, pins);
        if (wait_us !== w.wait_us) report("wait_before_us", w.wait_us, wait_us);
        if (last_flag !== w.last_flag) report("last", w.last_flag, last_flag);
    endfunction
endclass

module char_lcd_nibble_write_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 90;
    localparam int PHASES           = 5;
    localparam int SETTLE_CYCLES    = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = '0;    // [2:0] action
    logic [23:0] s_axis_tdata = '0;    // [7:0] code, [10:8] line, [16:11] column
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;         // [7:0] pins, [23:8] wait_before_us
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lcd_write_scoreboard sb;

    // Pacing knobs, changed between phases.
    int stall_pct = 0;
    int stall_max = 1;
    int stall_left = 0;
    int gap_max = 0;
    int burst_left = 0;

    char_lcd_nibble_write_sequencer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure: random stall runs of random length.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready = 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(stall_max);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Record every accepted request and check every accepted pin write.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[10:8],
                                s_axis_tdata[16:11]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_write(m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast);
            end
        end
    end

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(addr, data);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Presents one request, inserting an idle gap when a burst runs out and gaps are enabled.
    task automatic send_request(input logic [2:0] action, input logic [7:0] code_val,
                                input logic [2:0] line_no, input logic [5:0] column);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0) begin
                gap = $urandom_range(1, gap_max);
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = action;
        s_axis_tdata = {7'b0, column, line_no, code_val};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Mostly well-formed requests, with a few dropped ones mixed in.
    task automatic send_random_request();
        int sel;
        logic [2:0] action;
        logic [2:0] line_no;
        sel = $urandom_range(99);
        line_no = 3'($urandom_range(LINE_LAST_VALID));
        if (sel < 8) action = clcd_pkg::ACT_INIT;
        else if (sel < 33) action = clcd_pkg::ACT_COMMAND;
        else if (sel < 63) action = clcd_pkg::ACT_TEXT;
        else if (sel < 71) action = clcd_pkg::ACT_CLEAR;
        else if (sel < 95) action = clcd_pkg::ACT_SETPOS;
        else action = 3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
        if (sel >= 91 && sel < 95) begin
            line_no = 3'($urandom_range(LINE_LAST_VALID + 1, 7));
        end
        send_request(action, 8'($urandom), line_no, 6'($urandom));
    endtask

    // Waits until every expected write has come out and the block is quiet.
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [2:0]  act;
        logic [7:0]  pulse_val;
        logic [15:0] cmd_val;
        logic [15:0] clr_val;
        logic [31:0] noise;
        sb = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests with the reset timing.
        stall_pct = 20;
        stall_max = 4;
        gap_max = 3;
        send_request(clcd_pkg::ACT_INIT, 8'h00, 3'd0, 6'd0);
        send_request(clcd_pkg::ACT_COMMAND, 8'h00, 3'd0, 6'd0);
        send_request(clcd_pkg::ACT_COMMAND, 8'hFF, 3'd7, 6'd63);
        send_request(clcd_pkg::ACT_TEXT, 8'h00, 3'd0, 6'd0);
        send_request(clcd_pkg::ACT_TEXT, 8'hFF, 3'd7, 6'd63);
        send_request(clcd_pkg::ACT_TEXT, 8'hA5, 3'd2, 6'd21);
        send_request(clcd_pkg::ACT_COMMAND, 8'h5A, 3'd5, 6'd42);
        send_request(clcd_pkg::ACT_CLEAR, 8'hFF, 3'd7, 6'd63);
        send_request(clcd_pkg::ACT_SETPOS, 8'h00, 3'd0, 6'd0);
        send_request(clcd_pkg::ACT_SETPOS, 8'hFF, 3'd1, 6'd63);
        send_request(clcd_pkg::ACT_SETPOS, 8'h3C, 3'd2, 6'd21);
        // Line 3 at the last column wraps past the top of the address range.
        send_request(clcd_pkg::ACT_SETPOS, 8'hC3, 3'd3, 6'd63);
        for (int ln = LINE_LAST_VALID + 1; ln <= 7; ln++) begin
            send_request(clcd_pkg::ACT_SETPOS, 8'($urandom), 3'(ln), 6'($urandom));
        end
        for (int a = ACT_FIRST_UNUSED; a <= ACT_LAST_UNUSED; a++) begin
            act = 3'(a);
            send_request(act, 8'($urandom), 3'($urandom), 6'($urandom));
        end
        send_request(clcd_pkg::ACT_TEXT, 8'h41, 3'd0, 6'd0);
        send_request(clcd_pkg::ACT_INIT, 8'hFF, 3'd7, 6'd63);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    pulse_val = 8'd0;
                    cmd_val = 16'd0;
                    clr_val = 16'd0;
                end
                1: begin
                    pulse_val = 8'hFF;
                    cmd_val = 16'hFFFF;
                    clr_val = 16'hFFFF;
                end
                4: begin
                    pulse_val = 8'($urandom_range(3));
                    cmd_val = 16'($urandom_range(100));
                    clr_val = 16'($urandom_range(45535, 65535));
                end
                default: begin
                    pulse_val = 8'($urandom);
                    cmd_val = 16'($urandom);
                    clr_val = 16'($urandom);
                end
            endcase
            // Upper data bits beyond each register's width carry noise.
            noise = $urandom;
            apb_write({clcd_pkg::REG_CLEAR_WAIT, 2'b00}, {noise[31:16], clr_val});
            apb_write({clcd_pkg::REG_ENABLE_PULSE, 2'b00}, {noise[31:8], pulse_val});
            apb_write({clcd_pkg::REG_COMMAND_WAIT, 2'b00}, {noise[15:0], cmd_val});
            apb_write({REG_SPARE, 2'b00}, $urandom);

            // Rotate between no idling, light idling and heavy idling.
            case (phase % 3)
                0: begin
                    stall_pct = 0;
                    gap_max = 0;
                end
                1: begin
                    stall_pct = 15;
                    stall_max = 3;
                    gap_max = 4;
                end
                default: begin
                    stall_pct = 45;
                    stall_max = 10;
                    gap_max = 12;
                end
            endcase

            // With maximal waits, init after clear saturates the first wait.
            if (phase == 1) begin
                send_request(clcd_pkg::ACT_CLEAR, 8'h00, 3'd0, 6'd0);
                send_request(clcd_pkg::ACT_INIT, 8'h00, 3'd0, 6'd0);
                send_request(clcd_pkg::ACT_INIT, 8'h00, 3'd0, 6'd0);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                send_random_request();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: char_lcd_nibble_write_sequencer.f
+incdir+sv
sv/clcd_pkg.sv
sv/clcd_front.sv
sv/clcd_queue.sv
sv/clcd_back.sv
sv/char_lcd_nibble_write_sequencer.sv
tb/sv/char_lcd_nibble_write_sequencer_tb.sv
